// ===== hdl/bpc_pkg.sv =====
// Shared types and constants for the barometric compensation pipeline.
// No dependencies; every other file in this block imports it.
package bpc_pkg;

  // Pressure path widths
  localparam int DVD_W    = 64;  // dividend and quotient width
  localparam int DEN_W    = 31;  // divisor magnitude width
  localparam int DIV_STEP = 2;   // quotient bits resolved per divider stage

  // Formula constants
  localparam int PRESS_OFFSET = 128000;
  localparam int ADC_FULL     = 1048576;
  localparam int DIV_SCALE    = 3125;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_TEMP_CAL = 2'd0,
    REG_PRESS_A  = 2'd1,
    REG_PRESS_B  = 2'd2,
    REG_PRESS_C  = 2'd3
  } reg_idx_t;

  // Unpacked calibration words
  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

  // Fields that ride alongside the pressure path
  typedef struct packed {
    logic signed [23:0] tf;
    logic signed [23:0] tc;
    logic               zero;
    logic               qneg;
  } carry_t;

endpackage

// ===== hdl/bpc_cfg.sv =====
// Configuration register file behind the APB-style port.
// Depends on bpc_pkg for register indexes and the calibration struct.
module bpc_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output bpc_pkg::cal_t       cal
);
  import bpc_pkg::*;

  logic [47:0] temp_cal_r;
  logic [63:0] press_a_r;
  logic [63:0] press_b_r;
  logic [15:0] press_c_r;
  reg_idx_t    idx;
  logic        wr;

  assign idx = reg_idx_t'(paddr[4:3]);
  assign wr  = psel & penable & pwrite;

  // Write the addressed register, dropping bits above its width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r <= '0;
      press_a_r  <= '0;
      press_b_r  <= '0;
      press_c_r  <= '0;
    end else if (wr) begin
      case (idx)
        REG_TEMP_CAL: temp_cal_r <= pwdata[47:0];
        REG_PRESS_A:  press_a_r  <= pwdata;
        REG_PRESS_B:  press_b_r  <= pwdata;
        REG_PRESS_C:  press_c_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_TEMP_CAL: prdata = {16'b0, temp_cal_r};
      REG_PRESS_A:  prdata = press_a_r;
      REG_PRESS_B:  prdata = press_b_r;
      REG_PRESS_C:  prdata = {48'b0, press_c_r};
      default:      prdata = '0;
    endcase
  end

  // Split into calibration words
  assign cal.t1 = temp_cal_r[15:0];
  assign cal.t2 = temp_cal_r[31:16];
  assign cal.t3 = temp_cal_r[47:32];
  assign cal.p1 = press_a_r[15:0];
  assign cal.p2 = press_a_r[31:16];
  assign cal.p3 = press_a_r[47:32];
  assign cal.p4 = press_a_r[63:48];
  assign cal.p5 = press_b_r[15:0];
  assign cal.p6 = press_b_r[31:16];
  assign cal.p7 = press_b_r[47:32];
  assign cal.p8 = press_b_r[63:48];
  assign cal.p9 = press_c_r;

endmodule

// ===== hdl/bpc_temp.sv =====
// Temperature compensation: four stages from raw burst to fine and centi temperature.
// Depends on bpc_pkg for the calibration struct and constants.
module bpc_temp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [47:0]        burst,
  input  bpc_pkg::cal_t      cal,
  output logic               out_valid,
  output logic signed [23:0] tf,
  output logic signed [23:0] tc,
  output logic signed [24:0] pa,
  output logic [20:0]        np
);
  import bpc_pkg::*;

  logic [19:0]        adc_t;
  logic [19:0]        adc_p;
  logic signed [17:0] x;
  logic signed [16:0] dd;
  logic signed [33:0] var1p_nxt;
  logic signed [33:0] dsq_nxt;
  logic [20:0]        np_nxt;

  logic               s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic signed [33:0] var1p_r;
  logic signed [33:0] dsq_r;
  logic [20:0]        np1_r, np2_r, np3_r, np4_r;
  logic signed [22:0] a1_r;
  logic signed [36:0] b2p_r;
  logic signed [22:0] a1_nxt;
  logic signed [36:0] b2p_nxt;
  logic signed [23:0] tf_nxt;
  logic signed [23:0] tf3_r, tf4_r, tc4_r;
  logic signed [26:0] tc_sum;
  logic signed [23:0] tc_nxt;
  logic signed [24:0] pa_nxt;
  logic signed [24:0] pa4_r;

  // Stage 1: differences and first products
  assign adc_t     = burst[23:4];
  assign adc_p     = burst[47:28];
  assign x         = $signed({1'b0, adc_t[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
  assign dd        = $signed({1'b0, adc_t[19:4]}) - $signed({1'b0, cal.t1});
  assign var1p_nxt = x * cal.t2;
  assign dsq_nxt   = dd * dd;
  assign np_nxt    = 21'(ADC_FULL) - {1'b0, adc_p};

  // Stage 2: scale var1, second product of var2
  assign a1_nxt  = $signed(var1p_r[33:11]);
  assign b2p_nxt = $signed({1'b0, dsq_r[31:12]}) * cal.t3;

  // Stage 3: fine temperature
  assign tf_nxt = 24'(a1_r) + 24'($signed(b2p_r[36:14]));

  // Stage 4: centi temperature and pressure offset
  assign tc_sum = (27'(tf3_r) <<< 2) + 27'(tf3_r) + 27'sd128;
  assign tc_nxt = 24'($signed(tc_sum[26:8]));
  assign pa_nxt = 25'(tf3_r) - 25'(PRESS_OFFSET);

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      var1p_r <= var1p_nxt;
      dsq_r   <= dsq_nxt;
      np1_r   <= np_nxt;
      a1_r    <= a1_nxt;
      b2p_r   <= b2p_nxt;
      np2_r   <= np1_r;
      tf3_r   <= tf_nxt;
      np3_r   <= np2_r;
      tf4_r   <= tf3_r;
      tc4_r   <= tc_nxt;
      pa4_r   <= pa_nxt;
      np4_r   <= np3_r;
    end
  end

  assign out_valid = s4_v_r;
  assign tf        = tf4_r;
  assign tc        = tc4_r;
  assign pa        = pa4_r;
  assign np        = np4_r;

endmodule

// ===== hdl/bpc_press_pre.sv =====
// Pressure path up to the division: var1/var2 products, divisor, dividend, signs.
// Depends on bpc_pkg for the calibration and carry structs and constants.
module bpc_press_pre (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [23:0]     tf,
  input  logic signed [23:0]     tc,
  input  logic signed [24:0]     pa,
  input  logic [20:0]            np,
  input  bpc_pkg::cal_t          cal,
  output logic                   out_valid,
  output logic [bpc_pkg::DVD_W-1:0] ma,
  output logic [bpc_pkg::DEN_W-1:0] mb,
  output bpc_pkg::carry_t        carry
);
  import bpc_pkg::*;

  localparam logic signed [63:0] BIAS47 = 64'sh0000_8000_0000_0000;

  logic [6:0]         v_r;
  carry_t             c5_r, c6_r, c7_r, c8_r, c9_r, c10_r, c11_r;
  logic [20:0]        np5_r, np6_r, np7_r;

  // stage 5
  logic signed [49:0] sq_full;
  logic [47:0]        sq_r;
  logic signed [40:0] ap5_r, ap2_r, ap5_6_r, ap2_6_r;
  // stage 6
  logic signed [40:0] lo6_nxt, hi6_nxt, lo3_nxt, hi3_nxt;
  logic signed [40:0] lo6_r, hi6_r, lo3_r, hi3_r;
  // stage 7
  logic [63:0]        b_nxt, b_r;
  logic signed [63:0] sqp3;
  logic signed [63:0] c_nxt, c_r;
  // stage 8
  logic [47:0]        cp_lo_nxt, cp_hi_full, cp_lo_r;
  logic [31:0]        cp_hi_r;
  logic [63:0]        e_nxt, e_r;
  // stage 9
  logic [63:0]        den_full;
  logic signed [30:0] den_r;
  logic [43:0]        el_nxt, el_r, eh_full;
  logic [31:0]        eh_r;
  // stage 10
  logic [63:0]        dvd_r;
  logic [30:0]        mb_nxt, mb10_r, mb11_r;
  logic               nb_r;
  // stage 11
  logic [63:0]        ma_r;

  // Stage 6 partial products of pa^2 times P6 and P3
  assign lo6_nxt = $signed({1'b0, sq_r[23:0]}) * cal.p6;
  assign hi6_nxt = $signed({1'b0, sq_r[47:24]}) * cal.p6;
  assign lo3_nxt = $signed({1'b0, sq_r[23:0]}) * cal.p3;
  assign hi3_nxt = $signed({1'b0, sq_r[47:24]}) * cal.p3;

  // Stage 7: combine into var2 and the divisor factor
  assign b_nxt = (64'(hi6_r) <<< 24) + 64'(lo6_r) + (64'(ap5_6_r) <<< 17)
               + (64'(cal.p4) <<< 35);
  assign sqp3  = (64'(hi3_r) <<< 24) + 64'(lo3_r);
  assign c_nxt = BIAS47 + (sqp3 >>> 8) + (64'(ap2_6_r) <<< 12);

  // Stage 8: times P1 in halves, start of the dividend
  assign cp_lo_nxt  = c_r[31:0] * cal.p1;
  assign cp_hi_full = c_r[63:32] * cal.p1;
  assign e_nxt      = ({43'b0, np7_r} << 31) - b_r;

  // Stage 9: divisor, dividend times scale in halves
  assign den_full = {cp_hi_r, 32'b0} + {16'b0, cp_lo_r};
  assign el_nxt   = e_r[31:0] * 12'(DIV_SCALE);
  assign eh_full  = e_r[63:32] * 12'(DIV_SCALE);

  // Stage 10: divisor magnitude
  assign mb_nxt = den_r[30] ? 31'(-den_r) : 31'(den_r);

  assign sq_full = pa * pa;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 5
      sq_r       <= sq_full[47:0];
      ap5_r      <= pa * cal.p5;
      ap2_r      <= pa * cal.p2;
      c5_r       <= '{tf: tf, tc: tc, zero: 1'b0, qneg: 1'b0};
      np5_r      <= np;
      // stage 6
      lo6_r      <= lo6_nxt;
      hi6_r      <= hi6_nxt;
      lo3_r      <= lo3_nxt;
      hi3_r      <= hi3_nxt;
      ap5_6_r    <= ap5_r;
      ap2_6_r    <= ap2_r;
      c6_r       <= c5_r;
      np6_r      <= np5_r;
      // stage 7
      b_r        <= b_nxt;
      c_r        <= c_nxt;
      c7_r       <= c6_r;
      np7_r      <= np6_r;
      // stage 8
      cp_lo_r    <= cp_lo_nxt;
      cp_hi_r    <= cp_hi_full[31:0];
      e_r        <= e_nxt;
      c8_r       <= c7_r;
      // stage 9
      den_r      <= $signed(den_full[63:33]);
      el_r       <= el_nxt;
      eh_r       <= eh_full[31:0];
      c9_r       <= c8_r;
      // stage 10
      dvd_r      <= {eh_r, 32'b0} + {20'b0, el_r};
      mb10_r     <= mb_nxt;
      nb_r       <= den_r[30];
      c10_r      <= '{tf: c9_r.tf, tc: c9_r.tc, zero: (den_r == '0), qneg: c9_r.qneg};
      // stage 11
      ma_r       <= dvd_r[63] ? (64'd0 - dvd_r) : dvd_r;
      mb11_r     <= mb10_r;
      c11_r      <= '{tf: c10_r.tf, tc: c10_r.tc, zero: c10_r.zero,
                      qneg: dvd_r[63] ^ nb_r};
    end
  end

  assign out_valid = v_r[6];
  assign ma        = ma_r;
  assign mb        = mb11_r;
  assign carry     = c11_r;

endmodule

// ===== hdl/bpc_div.sv =====
// Pipelined restoring divider for unsigned magnitudes, DIV_STEP quotient bits per stage.
// Depends on bpc_pkg for widths and the carry struct.
module bpc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [bpc_pkg::DVD_W-1:0] dividend,
  input  logic [bpc_pkg::DEN_W-1:0] divisor,
  input  bpc_pkg::carry_t           carry_in,
  output logic                      out_valid,
  output logic [bpc_pkg::DVD_W-1:0] quotient,
  output bpc_pkg::carry_t           carry_out
);
  import bpc_pkg::*;

  localparam int STAGES = DVD_W / DIV_STEP;

  logic [STAGES-1:0]    v_r;
  logic [DVD_W-1:0]     w_r   [STAGES];
  logic [DEN_W-1:0]     rem_r [STAGES];
  logic [DEN_W-1:0]     den_r [STAGES];
  carry_t               cy_r  [STAGES];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STAGES-2:0], in_valid};
    end
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [DVD_W-1:0] w_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    carry_t           cy_in;
    logic [DVD_W-1:0] w_nxt;
    logic [DEN_W-1:0] rem_nxt;

    // Take the block inputs in the first stage, the previous stage elsewhere
    if (g == 0) begin : g_first
      assign w_in   = dividend;
      assign rem_in = '0;
      assign den_in = divisor;
      assign cy_in  = carry_in;
    end else begin : g_rest
      assign w_in   = w_r[g-1];
      assign rem_in = rem_r[g-1];
      assign den_in = den_r[g-1];
      assign cy_in  = cy_r[g-1];
    end

    // Shift in dividend bits, subtract where the divisor fits
    always_comb begin
      logic [DEN_W-1:0] t;
      w_nxt   = w_in;
      rem_nxt = rem_in;
      for (int k = 0; k < DIV_STEP; k++) begin
        t     = {rem_nxt[DEN_W-2:0], w_nxt[DVD_W-1]};
        w_nxt = {w_nxt[DVD_W-2:0], 1'b0};
        if (t >= den_in) begin
          t        = t - den_in;
          w_nxt[0] = 1'b1;
        end
        rem_nxt = t;
      end
    end

    // Advance payload
    always_ff @(posedge clk) begin
      if (en) begin
        w_r[g]   <= w_nxt;
        rem_r[g] <= rem_nxt;
        den_r[g] <= den_in;
        cy_r[g]  <= cy_in;
      end
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign quotient  = w_r[STAGES-1];
  assign carry_out = cy_r[STAGES-1];

endmodule

// ===== hdl/bpc_press_post.sv =====
// Pressure path after the division: sign fix, P9/P8 terms, P7 offset, clamp, output register.
// Depends on bpc_pkg for the calibration and carry structs.
module bpc_press_post (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [bpc_pkg::DVD_W-1:0] quotient,
  input  bpc_pkg::carry_t           carry,
  input  bpc_pkg::cal_t             cal,
  output logic                      out_valid,
  output logic signed [31:0]        fine_temperature,
  output logic signed [23:0]        temperature_centi,
  output logic [31:0]               pressure_q24_8,
  output logic                      pressure_valid
);
  import bpc_pkg::*;

  logic [4:0]         v_r;
  logic               out_v_r;
  carry_t             c1_r, c2_r, c3_r, c4_r, c5_r;

  // P1
  logic [63:0]        q1_r;
  // P2
  logic [31:0]        sl;
  logic signed [18:0] sh;
  logic signed [51:0] slsh_full;
  logic signed [48:0] lo8_nxt, hi8_full;
  logic [63:0]        sl2_r, q2_r;
  logic [30:0]        slsh_r;
  logic signed [48:0] lo8_r;
  logic [31:0]        hi8_r;
  // P3
  logic [63:0]        p8sum;
  logic [63:0]        m_r, q3_r;
  logic signed [63:0] bt3_r;
  // P4
  logic signed [48:0] lo9_r, hi9_full;
  logic [31:0]        hi9_r;
  logic [63:0]        q4_r;
  logic signed [63:0] bt4_r;
  // P5
  logic [63:0]        p9sum;
  logic signed [63:0] s5_nxt, s5_r;
  // P6
  logic signed [63:0] r6;
  logic [31:0]        clamp;
  logic signed [31:0] tf_o_r;
  logic signed [23:0] tc_o_r;
  logic [31:0]        press_o_r;
  logic               pv_o_r;

  // P2: split asr(p,13) into halves, P8 product in halves
  assign sl        = q1_r[44:13];
  assign sh        = $signed(q1_r[63:45]);
  assign slsh_full = $signed({1'b0, sl}) * sh;
  assign lo8_nxt   = $signed({1'b0, q1_r[31:0]}) * cal.p8;
  assign hi8_full  = $signed({1'b0, q1_r[63:32]}) * cal.p8;

  // P3: square of the shifted pressure, P8 term
  assign p8sum = 64'(lo8_r) + {hi8_r, 32'b0};

  // P4: times P9 in halves
  assign hi9_full = $signed({1'b0, m_r[63:32]}) * cal.p9;

  // P5: sum of the three terms
  assign p9sum  = 64'(lo9_r) + {hi9_r, 32'b0};
  assign s5_nxt = $signed(q4_r) + ($signed(p9sum) >>> 25) + bt4_r;

  // P6: final scale, P7 offset, clamp to 32 bits
  assign r6 = (s5_r >>> 8) + (64'(cal.p7) <<< 4);
  always_comb begin
    if (r6[63]) begin
      clamp = '0;
    end else if (|r6[62:32]) begin
      clamp = '1;
    end else begin
      clamp = r6[31:0];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v_r     <= {v_r[3:0], in_valid};
      out_v_r <= v_r[4];
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      q1_r      <= carry.qneg ? (64'd0 - quotient) : quotient;
      c1_r      <= carry;
      sl2_r     <= sl * sl;
      slsh_r    <= slsh_full[30:0];
      lo8_r     <= lo8_nxt;
      hi8_r     <= hi8_full[31:0];
      q2_r      <= q1_r;
      c2_r      <= c1_r;
      m_r       <= sl2_r + {slsh_r, 33'b0};
      bt3_r     <= $signed(p8sum) >>> 19;
      q3_r      <= q2_r;
      c3_r      <= c2_r;
      lo9_r     <= $signed({1'b0, m_r[31:0]}) * cal.p9;
      hi9_r     <= hi9_full[31:0];
      q4_r      <= q3_r;
      bt4_r     <= bt3_r;
      c4_r      <= c3_r;
      s5_r      <= s5_nxt;
      c5_r      <= c4_r;
      tf_o_r    <= 32'(c5_r.tf);
      tc_o_r    <= c5_r.tc;
      press_o_r <= c5_r.zero ? 32'd0 : clamp;
      pv_o_r    <= ~c5_r.zero;
    end
  end

  assign out_valid         = out_v_r;
  assign fine_temperature  = tf_o_r;
  assign temperature_centi = tc_o_r;
  assign pressure_q24_8    = press_o_r;
  assign pressure_valid    = pv_o_r;

endmodule

// ===== hdl/baro_temp_press_compensation.sv =====
// Barometric temperature and pressure compensation, one raw burst in per cycle unless stalled.
// The pipeline has 4 temperature stages, 7 pre-division stages, a 32-stage divider at
// 2 quotient bits per stage, and 6 post-division stages with the output register.
// Throughput is one item per cycle; a stall on the output freezes the whole pipeline.
// Reset clears all valid bits and the calibration registers to zero.
module baro_temp_press_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // raw_burst[47:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,   // fine_temperature[31:0], temperature_centi[55:32],
                                   // pressure_q24_8[87:56]
  output logic [0:0]  out_tuser,   // pressure_valid[0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import bpc_pkg::*;

  logic               en;
  cal_t               cal;

  logic               t_v;
  logic signed [23:0] t_tf, t_tc;
  logic signed [24:0] t_pa;
  logic [20:0]        t_np;

  logic               p_v;
  logic [DVD_W-1:0]   p_ma;
  logic [DEN_W-1:0]   p_mb;
  carry_t             p_c;

  logic               d_v;
  logic [DVD_W-1:0]   d_q;
  carry_t             d_c;

  logic signed [31:0] o_tf;
  logic signed [23:0] o_tc;
  logic [31:0]        o_press;
  logic               o_pv;

  // Advance everything unless the output holds an item not yet taken
  assign en         = ~out_tvalid | out_tready;
  assign in_tready  = en;
  assign cfg_pready = 1'b1;

  bpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cal     (cal)
  );

  bpc_temp u_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .burst     (in_tdata),
    .cal       (cal),
    .out_valid (t_v),
    .tf        (t_tf),
    .tc        (t_tc),
    .pa        (t_pa),
    .np        (t_np)
  );

  bpc_press_pre u_pre (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (t_v),
    .tf        (t_tf),
    .tc        (t_tc),
    .pa        (t_pa),
    .np        (t_np),
    .cal       (cal),
    .out_valid (p_v),
    .ma        (p_ma),
    .mb        (p_mb),
    .carry     (p_c)
  );

  bpc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p_v),
    .dividend  (p_ma),
    .divisor   (p_mb),
    .carry_in  (p_c),
    .out_valid (d_v),
    .quotient  (d_q),
    .carry_out (d_c)
  );

  bpc_press_post u_post (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (en),
    .in_valid          (d_v),
    .quotient          (d_q),
    .carry             (d_c),
    .cal               (cal),
    .out_valid         (out_tvalid),
    .fine_temperature  (o_tf),
    .temperature_centi (o_tc),
    .pressure_q24_8    (o_press),
    .pressure_valid    (o_pv)
  );

  assign out_tdata = {o_press, o_tc, o_tf};
  assign out_tuser = o_pv;

endmodule
